[rtl/canopen_valve_node_protocol_core_macros.svh]
// assertion macros shared by the canopen valve node checker files
// no dependencies; take it in by `include with the bare file name
`ifndef CANOPEN_VALVE_NODE_PROTOCOL_CORE_MACROS_SVH
`define CANOPEN_VALVE_NODE_PROTOCOL_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CVN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CVN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cvn_pkg.sv]
// types and constants of the canopen valve node core
// no dependencies; used by every module of the block
package cvn_pkg;

	// received frame or millisecond tick
	typedef struct packed {
		logic       operation;
		logic [10:0] frame_id;
		logic [3:0] frame_length;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
		logic [7:0] byte4;
	} cvn_in_t;

	// one result item
	typedef struct packed {
		logic [2:0]         result_kind;
		logic [10:0]        out_id;
		logic [3:0]         out_length;
		logic [7:0]         out_byte0;
		logic [7:0]         out_byte1;
		logic [7:0]         out_byte2;
		logic [7:0]         out_byte3;
		logic signed [15:0] plant_command;
		logic               last;
	} cvn_out_t;

	// configuration registers as seen by front and back
	typedef struct packed {
		logic [6:0]  node_id;
		logic [15:0] heartbeat_period_ms;
		logic [31:0] fail_delay_ms;
	} cvn_cfg_t;

	// decoded command classes carried through the queue
	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_NMT_START = 3'd1,
		OP_NMT_PREOP = 3'd2,
		OP_SETPOINT  = 3'd3,
		OP_SYNC      = 3'd4,
		OP_SDO       = 3'd5
	} cvn_op_t;

	// queue entry
	typedef struct packed {
		cvn_op_t    op;
		logic       mode_wr;
		logic       mode_sync;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
	} cvn_cmd_t;

	// result kinds
	localparam logic [2:0] KIND_HEARTBEAT = 3'd0;
	localparam logic [2:0] KIND_SDO_RESP  = 3'd1;
	localparam logic [2:0] KIND_STEP      = 3'd2;
	localparam logic [2:0] KIND_FEEDBACK  = 3'd3;
	localparam logic [2:0] KIND_FAILURE   = 3'd4;

	// operation field
	localparam logic OPERATION_TICK = 1'b1;

	// cob-id bases
	localparam logic [10:0] COB_NMT       = 11'h000;
	localparam logic [10:0] COB_SYNC      = 11'h080;
	localparam logic [10:0] COB_TPDO1     = 11'h180;
	localparam logic [10:0] COB_RPDO1     = 11'h200;
	localparam logic [10:0] COB_SDO_TX    = 11'h580;
	localparam logic [10:0] COB_SDO_RX    = 11'h600;
	localparam logic [10:0] COB_HEARTBEAT = 11'h700;

	// nmt commands and heartbeat states
	localparam logic [7:0] NMT_START       = 8'h01;
	localparam logic [7:0] NMT_STOP        = 8'h02;
	localparam logic [7:0] NMT_ENTER_PREOP = 8'h80;
	localparam logic [7:0] NMT_BROADCAST   = 8'h00;
	localparam logic [7:0] HB_OPERATIONAL  = 8'h05;
	localparam logic [7:0] HB_PREOP        = 8'h7F;

	// sdo
	localparam logic [7:0]  SDO_DL_RESP    = 8'h60;
	localparam logic [15:0] OD_TPDO1_COMM  = 16'h1800;
	localparam logic [7:0]  SUB_TRANS_TYPE = 8'h02;
	localparam logic [7:0]  MODE_SYNC_VAL  = 8'h01;

	// frame lengths
	localparam logic [3:0] LEN_HEARTBEAT = 4'd1;
	localparam logic [3:0] LEN_SDO       = 4'd8;
	localparam logic [3:0] LEN_FEEDBACK  = 4'd5;
	localparam logic [3:0] LEN_NMT_MIN   = 4'd2;
	localparam logic [3:0] LEN_RPDO_MIN  = 4'd3;
	localparam logic [3:0] LEN_SDO_MIN   = 4'd4;
	localparam logic [3:0] LEN_SDO_DATA  = 4'd5;

	// configuration register indexes and reset values
	localparam logic [1:0]  CFG_NODE_ID    = 2'd0;
	localparam logic [1:0]  CFG_HB_PERIOD  = 2'd1;
	localparam logic [1:0]  CFG_FAIL_DELAY = 2'd2;
	localparam logic [6:0]  NODE_ID_RST    = 7'd32;
	localparam logic [15:0] HB_PERIOD_RST  = 16'd100;
	localparam logic [31:0] FAIL_DELAY_RST = 32'd0;

	// command queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

endpackage

[rtl/cvn_front.sv]
// front end: classifies a received frame or tick into a queue command
// depends on cvn_pkg
module cvn_front (
	input  logic [6:0]        node_id,
	input  cvn_pkg::cvn_in_t  item,
	output logic              keep,
	output cvn_pkg::cvn_cmd_t cmd
);

	logic [10:0] id_rpdo;
	logic [10:0] id_sdo;
	logic        node_match;

	// identifiers that depend on the node number
	assign id_rpdo    = cvn_pkg::COB_RPDO1 + {4'd0, node_id};
	assign id_sdo     = cvn_pkg::COB_SDO_RX + {4'd0, node_id};
	assign node_match = (item.byte1 == {1'b0, node_id}) ||
		(item.byte1 == cvn_pkg::NMT_BROADCAST);

	// classification, in the priority order of the identifier checks
	always_comb begin
		keep          = 1'b0;
		cmd.op        = cvn_pkg::OP_TICK;
		cmd.mode_wr   = 1'b0;
		cmd.mode_sync = (item.byte4 == cvn_pkg::MODE_SYNC_VAL);
		cmd.b0        = item.byte0;
		cmd.b1        = item.byte1;
		cmd.b2        = item.byte2;
		cmd.b3        = item.byte3;
		if (item.operation == cvn_pkg::OPERATION_TICK) begin
			keep = 1'b1;
		end else if (item.frame_id == cvn_pkg::COB_NMT) begin
			if (item.frame_length >= cvn_pkg::LEN_NMT_MIN && node_match) begin
				if (item.byte0 == cvn_pkg::NMT_START) begin
					keep   = 1'b1;
					cmd.op = cvn_pkg::OP_NMT_START;
				end else if (item.byte0 == cvn_pkg::NMT_STOP ||
					item.byte0 == cvn_pkg::NMT_ENTER_PREOP) begin
					keep   = 1'b1;
					cmd.op = cvn_pkg::OP_NMT_PREOP;
				end
			end
		end else if (item.frame_id == id_rpdo) begin
			if (item.frame_length >= cvn_pkg::LEN_RPDO_MIN) begin
				keep   = 1'b1;
				cmd.op = cvn_pkg::OP_SETPOINT;
			end
		end else if (item.frame_id == cvn_pkg::COB_SYNC) begin
			keep   = 1'b1;
			cmd.op = cvn_pkg::OP_SYNC;
		end else if (item.frame_id == id_sdo) begin
			if (item.frame_length >= cvn_pkg::LEN_SDO_MIN) begin
				keep        = 1'b1;
				cmd.op      = cvn_pkg::OP_SDO;
				cmd.mode_wr = ({item.byte2, item.byte1} == cvn_pkg::OD_TPDO1_COMM) &&
					(item.byte3 == cvn_pkg::SUB_TRANS_TYPE) &&
					(item.frame_length >= cvn_pkg::LEN_SDO_DATA);
			end
		end
	end

endmodule

[rtl/cvn_fifo.sv]
// short command queue between front and back end
// depends on cvn_pkg
module cvn_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cvn_pkg::cvn_cmd_t din,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output cvn_pkg::cvn_cmd_t head
);

	cvn_pkg::cvn_cmd_t                mem_q [cvn_pkg::QDEPTH];
	logic [cvn_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [cvn_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [cvn_pkg::QCNT_W-1:0]       count_q;

	assign full       = (count_q == cvn_pkg::QCNT_W'(cvn_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

[rtl/cvn_back.sv]
// back end: node state, timers and result generation with an output register
// depends on cvn_pkg
module cvn_back #(
	parameter int TIME_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cvn_pkg::cvn_cfg_t cfg,
	input  logic              head_valid,
	input  cvn_pkg::cvn_cmd_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output cvn_pkg::cvn_out_t out_item
);

	localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

	// node state
	logic                 operational_q;
	logic                 ever_operational_q;
	logic                 failure_done_q;
	logic                 sync_feedback_q;
	logic                 drive_enable_q;
	logic [15:0]          command_raw_q;
	logic [TIME_BITS-1:0] operational_since_q;
	logic [TIME_BITS-1:0] time_now_q;
	logic [TIME_BITS-1:0] last_heartbeat_q;

	// next state
	logic                 operational_d;
	logic                 ever_operational_d;
	logic                 failure_done_d;
	logic                 sync_feedback_d;
	logic                 drive_enable_d;
	logic [15:0]          command_raw_d;
	logic [TIME_BITS-1:0] operational_since_d;
	logic [TIME_BITS-1:0] time_now_d;
	logic [TIME_BITS-1:0] last_heartbeat_d;

	// output register and the held second result
	logic                 out_valid_q;
	logic                 pend_valid_q;
	cvn_pkg::cvn_out_t    out_q;
	cvn_pkg::cvn_out_t    pend_q;

	logic                 out_free;
	logic [TIME_BITS-1:0] time_inc;
	logic [TIME_BITS-1:0] hb_diff;
	logic [TIME_BITS-1:0] fail_diff;
	logic                 hb_fire;
	logic                 fail_fire;
	logic [1:0]           n_res;
	cvn_pkg::cvn_out_t    res0;
	cvn_pkg::cvn_out_t    res1;
	cvn_pkg::cvn_out_t    r_hb;
	cvn_pkg::cvn_out_t    r_fail;
	cvn_pkg::cvn_out_t    r_step;
	cvn_pkg::cvn_out_t    r_fb;
	cvn_pkg::cvn_out_t    r_sdo;

	assign out_free  = !out_valid_q || out_ready;
	assign pop       = head_valid && !pend_valid_q && out_free;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// tick timers
	assign time_inc  = time_now_q + 1'b1;
	assign hb_diff   = time_inc - last_heartbeat_q;
	assign fail_diff = time_inc - operational_since_q;
	assign hb_fire   = hb_diff >= TIME_BITS'(cfg.heartbeat_period_ms);
	assign fail_fire = (cfg.fail_delay_ms != '0) && !failure_done_q && ever_operational_q &&
		(CMP_W'(fail_diff) >= CMP_W'(cfg.fail_delay_ms));

	// result templates
	always_comb begin
		r_hb             = '0;
		r_hb.result_kind = cvn_pkg::KIND_HEARTBEAT;
		r_hb.out_id      = cvn_pkg::COB_HEARTBEAT + {4'd0, cfg.node_id};
		r_hb.out_length  = cvn_pkg::LEN_HEARTBEAT;
		r_hb.out_byte0   = operational_q ? cvn_pkg::HB_OPERATIONAL : cvn_pkg::HB_PREOP;

		r_fail             = '0;
		r_fail.result_kind = cvn_pkg::KIND_FAILURE;

		r_step               = '0;
		r_step.result_kind   = cvn_pkg::KIND_STEP;
		r_step.plant_command = drive_enable_q ? signed'(command_raw_q) : '0;

		r_fb             = '0;
		r_fb.result_kind = cvn_pkg::KIND_FEEDBACK;
		r_fb.out_id      = cvn_pkg::COB_TPDO1 + {4'd0, cfg.node_id};
		r_fb.out_length  = cvn_pkg::LEN_FEEDBACK;

		r_sdo             = '0;
		r_sdo.result_kind = cvn_pkg::KIND_SDO_RESP;
		r_sdo.out_id      = cvn_pkg::COB_SDO_TX + {4'd0, cfg.node_id};
		r_sdo.out_length  = cvn_pkg::LEN_SDO;
		r_sdo.out_byte0   = cvn_pkg::SDO_DL_RESP;
		r_sdo.out_byte1   = head.b1;
		r_sdo.out_byte2   = head.b2;
		r_sdo.out_byte3   = head.b3;
	end

	// command execution: next state and up to two results
	always_comb begin
		operational_d       = operational_q;
		ever_operational_d  = ever_operational_q;
		failure_done_d      = failure_done_q;
		sync_feedback_d     = sync_feedback_q;
		drive_enable_d      = drive_enable_q;
		command_raw_d       = command_raw_q;
		operational_since_d = operational_since_q;
		time_now_d          = time_now_q;
		last_heartbeat_d    = last_heartbeat_q;
		n_res               = 2'd0;
		res0                = r_step;
		res1                = r_fb;
		case (head.op)
			cvn_pkg::OP_TICK: begin
				time_now_d = time_inc;
				if (hb_fire) begin
					last_heartbeat_d = time_inc;
				end
				if (fail_fire) begin
					failure_done_d = 1'b1;
				end
				if (hb_fire) begin
					res0  = r_hb;
					res1  = r_fail;
					n_res = fail_fire ? 2'd2 : 2'd1;
				end else if (fail_fire) begin
					res0  = r_fail;
					n_res = 2'd1;
				end
			end
			cvn_pkg::OP_NMT_START: begin
				operational_d = 1'b1;
				if (!ever_operational_q) begin
					ever_operational_d  = 1'b1;
					operational_since_d = time_now_q;
				end
			end
			cvn_pkg::OP_NMT_PREOP: begin
				operational_d = 1'b0;
			end
			cvn_pkg::OP_SETPOINT: begin
				if (operational_q) begin
					command_raw_d  = {head.b1, head.b0};
					drive_enable_d = head.b2[7];
					n_res          = sync_feedback_q ? 2'd1 : 2'd2;
				end
			end
			cvn_pkg::OP_SYNC: begin
				if (operational_q && sync_feedback_q) begin
					n_res = 2'd2;
				end
			end
			cvn_pkg::OP_SDO: begin
				if (head.mode_wr) begin
					sync_feedback_d = head.mode_sync;
				end
				res0  = r_sdo;
				n_res = 2'd1;
			end
			default: begin
				n_res = 2'd0;
			end
		endcase
		res0.last = (n_res == 2'd1);
		res1.last = 1'b1;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operational_q       <= 1'b0;
			ever_operational_q  <= 1'b0;
			failure_done_q      <= 1'b0;
			sync_feedback_q     <= 1'b0;
			drive_enable_q      <= 1'b0;
			command_raw_q       <= '0;
			operational_since_q <= '0;
			time_now_q          <= '0;
			last_heartbeat_q    <= '0;
		end else if (pop) begin
			operational_q       <= operational_d;
			ever_operational_q  <= ever_operational_d;
			failure_done_q      <= failure_done_d;
			sync_feedback_q     <= sync_feedback_d;
			drive_enable_q      <= drive_enable_d;
			command_raw_q       <= command_raw_d;
			operational_since_q <= operational_since_d;
			time_now_q          <= time_now_d;
			last_heartbeat_q    <= last_heartbeat_d;
		end
	end

	// output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (pop && n_res != 2'd0) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= (n_res == 2'd2);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (pop) begin
				out_q  <= res0;
				pend_q <= res1;
			end
		end
	end

endmodule

[rtl/canopen_valve_node_protocol_core.sv]
// Minimal CANopen node core (NMT, setpoint PDO, SYNC, expedited SDO, heartbeat and a
// one-shot failure trigger). Items are received frames or millisecond ticks on in_item;
// results (heartbeat, SDO response, plant step, feedback request, failure trigger) leave
// on out_item, with last set on the final result of each item. An accepted item enters a
// two-entry command queue after classification and is executed from the queue head once
// the output register is free and no second result is held. The back end retires one
// item per cycle while out_ready is high, but an item with two results holds the queue
// head until its second result has moved into the single output register, which moves one
// result a cycle when out_ready allows; a full queue holds in_ready low.
// Registers on the cfg port: 0 node_id, 1 heartbeat_period_ms, 2 fail_delay_ms, always
// ready; other indexes are ignored. Timer width is TIME_BITS (16 to 64), wrapping.
// depends on cvn_pkg, cvn_front, cvn_fifo, cvn_back
module canopen_valve_node_protocol_core #(
	parameter int TIME_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cvn_pkg::cvn_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output cvn_pkg::cvn_out_t out_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	cvn_pkg::cvn_cfg_t cfg_q;
	cvn_pkg::cvn_cmd_t cmd;
	cvn_pkg::cvn_cmd_t head;
	logic              keep;
	logic              full;
	logic              push;
	logic              pop;
	logic              head_valid;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;
	assign push      = in_valid && !full && keep;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_id             <= cvn_pkg::NODE_ID_RST;
			cfg_q.heartbeat_period_ms <= cvn_pkg::HB_PERIOD_RST;
			cfg_q.fail_delay_ms       <= cvn_pkg::FAIL_DELAY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				cvn_pkg::CFG_NODE_ID:    cfg_q.node_id             <= cfg_data[6:0];
				cvn_pkg::CFG_HB_PERIOD:  cfg_q.heartbeat_period_ms <= cfg_data[15:0];
				cvn_pkg::CFG_FAIL_DELAY: cfg_q.fail_delay_ms       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// classification
	cvn_front u_front (
		.node_id (cfg_q.node_id),
		.item    (in_item),
		.keep    (keep),
		.cmd     (cmd)
	);

	// command queue
	cvn_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.din        (cmd),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// execution and output
	cvn_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

[rtl/cvn_props.sv]
// port-level properties of the canopen valve node core, bound to the top level
// depends on cvn_pkg and canopen_valve_node_protocol_core_macros.svh
`include "canopen_valve_node_protocol_core_macros.svh"

module cvn_props (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input cvn_pkg::cvn_out_t out_item
);

	// a stalled result holds
	`CVN_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")

	// the second result of an item follows right behind the first
	`CVN_ASSERT_NXT(a_pair_follows, clk, arst_n, out_valid && out_ready && !out_item.last, out_valid, "second result missing")

	// heartbeat frames carry one state byte
	`CVN_ASSERT_IMP(a_hb_form, clk, arst_n, out_valid && out_item.result_kind == cvn_pkg::KIND_HEARTBEAT, out_item.out_length == cvn_pkg::LEN_HEARTBEAT && (out_item.out_byte0 == cvn_pkg::HB_OPERATIONAL || out_item.out_byte0 == cvn_pkg::HB_PREOP), "bad heartbeat")

	// only a plant step carries a command
	`CVN_ASSERT_IMP(a_cmd_step_only, clk, arst_n, out_valid && out_item.result_kind != cvn_pkg::KIND_STEP, out_item.plant_command == '0, "command on non-step result")

	// the failure trigger is always the closing result
	`CVN_ASSERT_IMP(a_fail_last, clk, arst_n, out_valid && out_item.result_kind == cvn_pkg::KIND_FAILURE, out_item.last && out_item.out_id == '0, "failure trigger not last")

endmodule

bind canopen_valve_node_protocol_core cvn_props u_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

[tb/testbench.sv]
// self-checking testbench for the canopen valve node core (canopen_valve_node_protocol_core)
// drives frames and millisecond ticks, predicts every result item and compares in order
// depends on cvn_pkg and the rtl of the core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic       OPERATION_FRAME = 1'b0;
	localparam logic [1:0] CFG_UNUSED      = 2'd3;
	localparam int         DRAIN_CYCLES    = 12;
	localparam int         LONG_HOLD       = 300;
	localparam int         PHASE_ITEMS     = 180;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	cvn_pkg::cvn_in_t  in_item;
	logic              out_valid;
	logic              out_ready;
	cvn_pkg::cvn_out_t out_item;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [31:0]       cfg_data;

	canopen_valve_node_protocol_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// node model: registers
	logic [6:0]  cfg_node;
	logic [15:0] cfg_hb_period;
	logic [31:0] cfg_fail_delay;

	// node model: nmt, timers, setpoint
	bit          is_operational;
	bit          was_operational;
	bit          failure_sent;
	bit          sync_mode;
	bit          drive_on;
	logic [31:0] op_since_ms;
	logic [31:0] now_ms;
	logic [31:0] last_hb_ms;
	logic [15:0] setpoint_raw;

	cvn_pkg::cvn_out_t step_results[$];
	cvn_pkg::cvn_out_t awaited_results[$];
	int unsigned       mismatch_count;

	bit          hold_wanted;
	bit          hold_done;

	typedef struct {
		bit                cfg_wr;
		logic [1:0]        reg_index;
		logic [31:0]       reg_data;
		cvn_pkg::cvn_in_t  item;
		bit                typed;
		cvn_pkg::cvn_out_t typed_result;
	} stim_row_t;

	stim_row_t directed_rows[$];

	function automatic cvn_pkg::cvn_out_t make_result(logic [2:0] kind, logic [10:0] id,
			logic [3:0] len, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3,
			logic [15:0] cmd, logic fin);
		cvn_pkg::cvn_out_t r;
		r.result_kind   = kind;
		r.out_id        = id;
		r.out_length    = len;
		r.out_byte0     = b0;
		r.out_byte1     = b1;
		r.out_byte2     = b2;
		r.out_byte3     = b3;
		r.plant_command = cmd;
		r.last          = fin;
		return r;
	endfunction

	function automatic cvn_pkg::cvn_in_t frame(logic [10:0] id, logic [3:0] len,
			logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3, logic [7:0] b4);
		cvn_pkg::cvn_in_t it;
		it.operation    = OPERATION_FRAME;
		it.frame_id     = id;
		it.frame_length = len;
		it.byte0        = b0;
		it.byte1        = b1;
		it.byte2        = b2;
		it.byte3        = b3;
		it.byte4        = b4;
		return it;
	endfunction

	function automatic cvn_pkg::cvn_in_t tick_item();
		cvn_pkg::cvn_in_t it;
		it           = frame(11'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
		it.operation = cvn_pkg::OPERATION_TICK;
		return it;
	endfunction

	// reset state of the node model
	function automatic void node_reset();
		cfg_node        = cvn_pkg::NODE_ID_RST;
		cfg_hb_period   = cvn_pkg::HB_PERIOD_RST;
		cfg_fail_delay  = cvn_pkg::FAIL_DELAY_RST;
		is_operational  = 1'b0;
		was_operational = 1'b0;
		failure_sent    = 1'b0;
		sync_mode       = 1'b0;
		drive_on        = 1'b0;
		op_since_ms     = '0;
		now_ms          = '0;
		last_hb_ms      = '0;
		setpoint_raw    = '0;
	endfunction

	function automatic void node_config(logic [1:0] idx, logic [31:0] data);
		case (idx)
			cvn_pkg::CFG_NODE_ID:    cfg_node = data[6:0];
			cvn_pkg::CFG_HB_PERIOD:  cfg_hb_period = data[15:0];
			cvn_pkg::CFG_FAIL_DELAY: cfg_fail_delay = data;
			default:                 ;
		endcase
	endfunction

	// results of one item into step_results, node state updated
	function automatic void node_step(cvn_pkg::cvn_in_t it);
		logic [10:0] own;
		logic [10:0] fb_id;
		logic [15:0] cmd_now;
		own     = {4'd0, cfg_node};
		fb_id   = cvn_pkg::COB_TPDO1 + own;
		cmd_now = drive_on ? setpoint_raw : 16'd0;
		step_results.delete();
		if (it.operation == cvn_pkg::OPERATION_TICK) begin
			now_ms = now_ms + 32'd1;
			if (now_ms - last_hb_ms >= {16'd0, cfg_hb_period}) begin
				last_hb_ms = now_ms;
				step_results.push_back(make_result(cvn_pkg::KIND_HEARTBEAT,
					cvn_pkg::COB_HEARTBEAT + own, cvn_pkg::LEN_HEARTBEAT,
					is_operational ? cvn_pkg::HB_OPERATIONAL : cvn_pkg::HB_PREOP,
					8'h00, 8'h00, 8'h00, 16'd0, 1'b0));
			end
			if (cfg_fail_delay != 0 && !failure_sent && was_operational &&
					now_ms - op_since_ms >= cfg_fail_delay) begin
				failure_sent = 1'b1;
				step_results.push_back(make_result(cvn_pkg::KIND_FAILURE, 11'd0, 4'd0,
					8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b0));
			end
		end else if (it.frame_id == cvn_pkg::COB_NMT) begin
			if (it.frame_length >= cvn_pkg::LEN_NMT_MIN &&
					(it.byte1 == {1'b0, cfg_node} || it.byte1 == cvn_pkg::NMT_BROADCAST)) begin
				if (it.byte0 == cvn_pkg::NMT_START) begin
					is_operational = 1'b1;
					if (!was_operational) begin
						was_operational = 1'b1;
						op_since_ms     = now_ms;
					end
				end else if (it.byte0 == cvn_pkg::NMT_STOP ||
						it.byte0 == cvn_pkg::NMT_ENTER_PREOP) begin
					is_operational = 1'b0;
				end
			end
		end else if (it.frame_id == cvn_pkg::COB_RPDO1 + own) begin
			if (is_operational && it.frame_length >= cvn_pkg::LEN_RPDO_MIN) begin
				step_results.push_back(make_result(cvn_pkg::KIND_STEP, 11'd0, 4'd0,
					8'h00, 8'h00, 8'h00, 8'h00, cmd_now, 1'b0));
				setpoint_raw = {it.byte1, it.byte0};
				drive_on     = it.byte2[7];
				if (!sync_mode)
					step_results.push_back(make_result(cvn_pkg::KIND_FEEDBACK, fb_id,
						cvn_pkg::LEN_FEEDBACK, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b0));
			end
		end else if (it.frame_id == cvn_pkg::COB_SYNC) begin
			if (is_operational && sync_mode) begin
				step_results.push_back(make_result(cvn_pkg::KIND_STEP, 11'd0, 4'd0,
					8'h00, 8'h00, 8'h00, 8'h00, cmd_now, 1'b0));
				step_results.push_back(make_result(cvn_pkg::KIND_FEEDBACK, fb_id,
					cvn_pkg::LEN_FEEDBACK, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b0));
			end
		end else if (it.frame_id == cvn_pkg::COB_SDO_RX + own) begin
			if (it.frame_length >= cvn_pkg::LEN_SDO_MIN) begin
				if ({it.byte2, it.byte1} == cvn_pkg::OD_TPDO1_COMM &&
						it.byte3 == cvn_pkg::SUB_TRANS_TYPE &&
						it.frame_length >= cvn_pkg::LEN_SDO_DATA)
					sync_mode = (it.byte4 == cvn_pkg::MODE_SYNC_VAL);
				step_results.push_back(make_result(cvn_pkg::KIND_SDO_RESP,
					cvn_pkg::COB_SDO_TX + own, cvn_pkg::LEN_SDO, cvn_pkg::SDO_DL_RESP,
					it.byte1, it.byte2, it.byte3, 16'd0, 1'b0));
			end
		end
		if (step_results.size() != 0)
			step_results[step_results.size() - 1].last = 1'b1;
	endfunction

	function automatic void add_row(cvn_pkg::cvn_in_t item, bit typed = 1'b0,
			cvn_pkg::cvn_out_t res = '0);
		stim_row_t row;
		row.cfg_wr       = 1'b0;
		row.reg_index    = cvn_pkg::CFG_NODE_ID;
		row.reg_data     = '0;
		row.item         = item;
		row.typed        = typed;
		row.typed_result = res;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_write(logic [1:0] idx, logic [31:0] data);
		stim_row_t row;
		row.cfg_wr       = 1'b1;
		row.reg_index    = idx;
		row.reg_data     = data;
		row.item         = '0;
		row.typed        = 1'b0;
		row.typed_result = '0;
		directed_rows.push_back(row);
	endfunction

	// data length, now and then outside the normal range
	function automatic logic [3:0] pick_length(int unsigned min_len);
		if ($urandom_range(0, 7) == 0)
			return 4'($urandom_range(0, 15));
		return 4'($urandom_range(min_len, 8));
	endfunction

	// random item aimed mostly at this node's own objects
	function automatic cvn_pkg::cvn_in_t random_item();
		cvn_pkg::cvn_in_t it;
		logic [10:0]      own;
		int unsigned      pick;
		own  = {4'd0, cfg_node};
		pick = $urandom_range(0, 99);
		it   = frame(11'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom));
		if (pick < 30) begin
			it = tick_item();
		end else if (pick < 45) begin
			it.frame_id     = cvn_pkg::COB_NMT;
			it.frame_length = pick_length(2);
			case ($urandom_range(0, 3))
				0, 1:    it.byte0 = cvn_pkg::NMT_START;
				2:       it.byte0 = $urandom_range(0, 1) ? cvn_pkg::NMT_STOP :
					cvn_pkg::NMT_ENTER_PREOP;
				default: ;
			endcase
			case ($urandom_range(0, 2))
				0:       it.byte1 = {1'b0, cfg_node};
				1:       it.byte1 = cvn_pkg::NMT_BROADCAST;
				default: ;
			endcase
		end else if (pick < 65) begin
			it.frame_id     = cvn_pkg::COB_RPDO1 + own;
			it.frame_length = pick_length(3);
		end else if (pick < 75) begin
			it.frame_id = cvn_pkg::COB_SYNC;
		end else if (pick < 88) begin
			it.frame_id     = cvn_pkg::COB_SDO_RX + own;
			it.frame_length = pick_length(4);
			if ($urandom_range(0, 1)) begin
				it.byte1 = cvn_pkg::OD_TPDO1_COMM[7:0];
				it.byte2 = cvn_pkg::OD_TPDO1_COMM[15:8];
				it.byte3 = cvn_pkg::SUB_TRANS_TYPE;
				if ($urandom_range(0, 1))
					it.byte4 = cvn_pkg::MODE_SYNC_VAL;
			end
		end
		return it;
	endfunction

	// offer one item and hold it until accepted, then record what it should produce
	task automatic send_item(cvn_pkg::cvn_in_t item, bit typed = 1'b0,
			cvn_pkg::cvn_out_t res = '0);
		in_valid <= 1'b1;
		in_item  <= item;
		do @(posedge clk); while (!in_ready);
		node_step(item);
		if (typed)
			awaited_results.push_back(res);
		else
			foreach (step_results[i])
				awaited_results.push_back(step_results[i]);
	endtask

	// random gap on the input side: mostly none, sometimes short, rarely long
	task automatic idle_gap();
		int unsigned r;
		int unsigned gap;
		r   = $urandom_range(0, 9);
		gap = (r < 6) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(5, 25);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write only once the core has gone quiet
	task automatic write_register(logic [1:0] idx, logic [31:0] data);
		in_valid <= 1'b0;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		node_config(idx, data);
	endtask

	task automatic random_burst(int unsigned count, bit with_hold);
		for (int unsigned i = 0; i < count; i++) begin
			send_item(random_item());
			if (with_hold && i == count / 3)
				hold_wanted = 1'b1;
			idle_gap();
		end
	endtask

	// output side: ready runs, short stalls, rare long stalls, one very long hold
	initial begin
		out_ready   = 1'b0;
		hold_wanted = 1'b0;
		hold_done   = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int unsigned r;
			r = $urandom_range(0, 99);
			if (hold_wanted && !hold_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else if (r < 50) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end else if (r < 90) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	// result checking against the oldest awaited item
	always @(posedge clk) begin : result_check
		cvn_pkg::cvn_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display({"unexpected result: kind %0d id %h len %0d ",
						"bytes %h %h %h %h cmd %0d last %b"},
						out_item.result_kind, out_item.out_id, out_item.out_length,
						out_item.out_byte0, out_item.out_byte1, out_item.out_byte2,
						out_item.out_byte3, out_item.plant_command, out_item.last);
			end else begin
				want = awaited_results.pop_front();
				if (out_item.result_kind !== want.result_kind ||
						out_item.out_id !== want.out_id ||
						out_item.out_length !== want.out_length ||
						out_item.out_byte0 !== want.out_byte0 ||
						out_item.out_byte1 !== want.out_byte1 ||
						out_item.out_byte2 !== want.out_byte2 ||
						out_item.out_byte3 !== want.out_byte3 ||
						out_item.plant_command !== want.plant_command ||
						out_item.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch at %t", $realtime);
						$display({"  expected: kind %0d id %h len %0d ",
							"bytes %h %h %h %h cmd %0d last %b"},
							want.result_kind, want.out_id, want.out_length, want.out_byte0,
							want.out_byte1, want.out_byte2, want.out_byte3,
							want.plant_command, want.last);
						$display({"  actual:   kind %0d id %h len %0d ",
							"bytes %h %h %h %h cmd %0d last %b"},
							out_item.result_kind, out_item.out_id, out_item.out_length,
							out_item.out_byte0, out_item.out_byte1, out_item.out_byte2,
							out_item.out_byte3, out_item.plant_command, out_item.last);
					end
				end
			end
		end
	end

	// stimulus
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_item        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = cvn_pkg::CFG_NODE_ID;
		cfg_data       = '0;
		mismatch_count = 0;
		node_reset();

		// directed part, default registers (node 32) until the first write
		add_row(frame(cvn_pkg::COB_SDO_RX + 11'd32, 4'd4, 8'h40, 8'h00, 8'h10, 8'h00, 8'h00),
			1'b1, make_result(cvn_pkg::KIND_SDO_RESP, cvn_pkg::COB_SDO_TX + 11'd32,
				cvn_pkg::LEN_SDO, cvn_pkg::SDO_DL_RESP, 8'h00, 8'h10, 8'h00, 16'd0, 1'b1));
		// setpoint and sync while pre-operational
		add_row(frame(cvn_pkg::COB_RPDO1 + 11'd32, 4'd8, 8'h12, 8'h34, 8'h80, 8'h00, 8'h00));
		add_row(frame(cvn_pkg::COB_SYNC, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		// nmt too short, for another node, then for this node
		add_row(frame(cvn_pkg::COB_NMT, 4'd1, cvn_pkg::NMT_START, cvn_pkg::NMT_BROADCAST,
			8'h00, 8'h00, 8'h00));
		add_row(frame(cvn_pkg::COB_NMT, 4'd2, cvn_pkg::NMT_START, 8'd33, 8'h00, 8'h00, 8'h00));
		add_row(frame(cvn_pkg::COB_NMT, 4'd2, cvn_pkg::NMT_START, 8'd32, 8'h00, 8'h00, 8'h00));
		// setpoints in event mode, extreme commands, length code above eight, then one too short
		add_row(frame(cvn_pkg::COB_RPDO1 + 11'd32, 4'd3, 8'hFF, 8'h7F, 8'h80, 8'h00, 8'h00));
		add_row(frame(cvn_pkg::COB_RPDO1 + 11'd32, 4'd15, 8'h00, 8'h80, 8'h80, 8'hFF, 8'hFF));
		add_row(frame(cvn_pkg::COB_RPDO1 + 11'd32, 4'd2, 8'h55, 8'h55, 8'h80, 8'h00, 8'h00));
		// switch to sync mode through 0x1800:02
		add_row(frame(cvn_pkg::COB_SDO_RX + 11'd32, 4'd5, 8'h2F, 8'h00, 8'h18, 8'h02, 8'h01),
			1'b1, make_result(cvn_pkg::KIND_SDO_RESP, cvn_pkg::COB_SDO_TX + 11'd32,
				cvn_pkg::LEN_SDO, cvn_pkg::SDO_DL_RESP, 8'h00, 8'h18, 8'h02, 16'd0, 1'b1));
		add_row(frame(cvn_pkg::COB_RPDO1 + 11'd32, 4'd3, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
		add_row(frame(cvn_pkg::COB_SYNC, 4'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		// same object but too short to carry the mode byte
		add_row(frame(cvn_pkg::COB_SDO_RX + 11'd32, 4'd4, 8'h2F, 8'h00, 8'h18, 8'h02, 8'h00),
			1'b1, make_result(cvn_pkg::KIND_SDO_RESP, cvn_pkg::COB_SDO_TX + 11'd32,
				cvn_pkg::LEN_SDO, cvn_pkg::SDO_DL_RESP, 8'h00, 8'h18, 8'h02, 16'd0, 1'b1));
		// broadcast enter pre-operational, sync ignored, start, stop, unknown command
		add_row(frame(cvn_pkg::COB_NMT, 4'd2, cvn_pkg::NMT_ENTER_PREOP, cvn_pkg::NMT_BROADCAST,
			8'h00, 8'h00, 8'h00));
		add_row(frame(cvn_pkg::COB_SYNC, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		add_row(frame(cvn_pkg::COB_NMT, 4'd2, cvn_pkg::NMT_START, cvn_pkg::NMT_BROADCAST,
			8'h00, 8'h00, 8'h00));
		add_row(frame(cvn_pkg::COB_NMT, 4'd8, cvn_pkg::NMT_STOP, 8'd32, 8'hFF, 8'hFF, 8'hFF));
		add_row(frame(cvn_pkg::COB_NMT, 4'd2, 8'h55, 8'd32, 8'h00, 8'h00, 8'h00));
		// back to event mode, then an unknown identifier and a short sdo
		add_row(frame(cvn_pkg::COB_SDO_RX + 11'd32, 4'd8, 8'h23, 8'h00, 8'h18, 8'h02, 8'hFE),
			1'b1, make_result(cvn_pkg::KIND_SDO_RESP, cvn_pkg::COB_SDO_TX + 11'd32,
				cvn_pkg::LEN_SDO, cvn_pkg::SDO_DL_RESP, 8'h00, 8'h18, 8'h02, 16'd0, 1'b1));
		add_row(frame(11'h7FF, 4'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		add_row(frame(cvn_pkg::COB_SDO_RX + 11'd32, 4'd3, 8'h40, 8'h00, 8'h18, 8'h02, 8'h01));
		// node id zero, heartbeat and failure on one tick
		add_write(cvn_pkg::CFG_NODE_ID, 32'd0);
		add_write(cvn_pkg::CFG_HB_PERIOD, 32'd1);
		add_write(cvn_pkg::CFG_FAIL_DELAY, 32'd1);
		add_row(tick_item());
		add_row(frame(cvn_pkg::COB_NMT, 4'd2, cvn_pkg::NMT_START, cvn_pkg::NMT_BROADCAST,
			8'h00, 8'h00, 8'h00));
		add_row(tick_item(), 1'b1,
			make_result(cvn_pkg::KIND_HEARTBEAT, cvn_pkg::COB_HEARTBEAT,
				cvn_pkg::LEN_HEARTBEAT, cvn_pkg::HB_OPERATIONAL,
				8'h00, 8'h00, 8'h00, 16'd0, 1'b1));
		// zero period: heartbeat on every tick
		add_write(cvn_pkg::CFG_HB_PERIOD, 32'd0);
		add_row(tick_item());
		add_row(tick_item());

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].cfg_wr) begin
				write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
			end else begin
				send_item(directed_rows[i].item, directed_rows[i].typed,
					directed_rows[i].typed_result);
				idle_gap();
			end
		end

		// random part over several register settings
		write_register(cvn_pkg::CFG_NODE_ID, 32'd127);
		write_register(cvn_pkg::CFG_HB_PERIOD, 32'd65535);
		write_register(cvn_pkg::CFG_FAIL_DELAY, 32'hFFFF_FFFF);
		write_register(CFG_UNUSED, $urandom);
		random_burst(PHASE_ITEMS, 1'b0);

		write_register(cvn_pkg::CFG_NODE_ID, 32'd1);
		write_register(cvn_pkg::CFG_HB_PERIOD, 32'd0);
		random_burst(PHASE_ITEMS, 1'b0);

		write_register(cvn_pkg::CFG_NODE_ID, 32'(cvn_pkg::NODE_ID_RST));
		write_register(cvn_pkg::CFG_HB_PERIOD, 32'(cvn_pkg::HB_PERIOD_RST));
		write_register(cvn_pkg::CFG_FAIL_DELAY, cvn_pkg::FAIL_DELAY_RST);
		random_burst(PHASE_ITEMS, 1'b1);

		// upper bits of the data must be dropped
		write_register(cvn_pkg::CFG_NODE_ID, $urandom);
		write_register(cvn_pkg::CFG_HB_PERIOD,
			($urandom & 32'hFFFF_0000) | $urandom_range(0, 20));
		write_register(cvn_pkg::CFG_FAIL_DELAY, $urandom);
		random_burst(PHASE_ITEMS, 1'b0);

		write_register(cvn_pkg::CFG_NODE_ID, 32'd0);
		write_register(cvn_pkg::CFG_HB_PERIOD, 32'd7);
		random_burst(PHASE_ITEMS, 1'b0);

		in_valid <= 1'b0;
		wait_drained();
		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// overall time limit
	initial begin
		#20_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/cvn_pkg.sv
rtl/cvn_front.sv
rtl/cvn_fifo.sv
rtl/cvn_back.sv
rtl/canopen_valve_node_protocol_core.sv
rtl/cvn_props.sv
tb/testbench.sv
